[rtl/lpcp_pkg.sv]
// Shared constants for the line pair closest points unit.
`default_nettype none

package lpcp_pkg;

   // multiplier partial product slice width
   localparam int CHUNK = 32;

   // tolerance register: unsigned Q0.16
   localparam int TOL_W = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

   // T^2 carries 2*TOL_W fraction bits
   localparam int TOL_SHIFT = 2 * TOL_W;

   // result status codes
   localparam logic [1:0] ST_SKEW       = 2'd0;
   localparam logic [1:0] ST_PARALLEL   = 2'd1;
   localparam logic [1:0] ST_DEGENERATE = 2'd2;
   localparam logic [1:0] ST_SATURATED  = 2'd3;

endpackage

`default_nettype wire

[rtl/lpcp_mul.sv]
// Pipelined signed multiplier: magnitude stage, 32x32 partial products, sum stage.
`default_nettype none

module lpcp_mul
   import lpcp_pkg::*;
#(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);

   localparam int NA = (AW + CHUNK - 1) / CHUNK;
   localparam int NB = (BW + CHUNK - 1) / CHUNK;
   localparam int PW = AW + BW;
   localparam int SW = (NA + NB) * CHUNK;

   logic [NA*CHUNK-1:0]  ua_ff, ua_in;
   logic [NB*CHUNK-1:0]  ub_ff, ub_in;
   logic                 neg1_ff;
   logic [2*CHUNK-1:0]   pp_ff [NA][NB];
   logic                 neg2_ff;
   logic [SW-1:0]        acc;
   logic signed [PW-1:0] p_ff, p_in;

   always_comb begin
      ua_in = '0;
      ub_in = '0;
      ua_in[AW-1:0] = a[AW-1] ? AW'(-a) : AW'(a);
      ub_in[BW-1:0] = b[BW-1] ? BW'(-b) : BW'(b);
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (SW'(pp_ff[i][j]) << (CHUNK * (i + j)));
         end
      end
      p_in = neg2_ff ? -$signed(acc[PW-1:0]) : $signed(acc[PW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg1_ff <= a[AW-1] ^ b[BW-1];
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= ua_ff[i*CHUNK +: CHUNK] * ub_ff[j*CHUNK +: CHUNK];
            end
         end
         neg2_ff <= neg1_ff;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

[rtl/line_pair_closest_points_3d_unit.sv]
// Closest points between two 3D lines: top level, fully pipelined.
//
// Usage:
//   req_* carries one line pair (points a0, a1, b0, b1, signed Q16.16), taken
//   when req_valid and req_ready are both high. rsp_* returns the closest
//   point on each line plus a status code, taken when rsp_valid and
//   rsp_ready are both high. csr_write/csr_wdata load the relative tolerance.
//   Throughput: one transaction per cycle unless the receiver stalls. A pair
//   passes through the dot product and multiplier stages, the restoring
//   divider that yields one quotient bit per stage, and the output
//   register.
//   The whole pipeline advances together; when the receiver stalls with a
//   result pending, every stage holds and req_ready drops, so nothing is
//   lost or repeated. A result is handed over and a new pair taken in the
//   same cycle when rsp_ready is high.
//   Reset clears all valid bits and loads the default tolerance.
`default_nettype none

module line_pair_closest_points_3d_unit
   import lpcp_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [TOL_W-1:0]              csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_a0_x,
   input  logic signed [COORD_WIDTH-1:0] req_a0_y,
   input  logic signed [COORD_WIDTH-1:0] req_a0_z,
   input  logic signed [COORD_WIDTH-1:0] req_a1_x,
   input  logic signed [COORD_WIDTH-1:0] req_a1_y,
   input  logic signed [COORD_WIDTH-1:0] req_a1_z,
   input  logic signed [COORD_WIDTH-1:0] req_b0_x,
   input  logic signed [COORD_WIDTH-1:0] req_b0_y,
   input  logic signed [COORD_WIDTH-1:0] req_b0_z,
   input  logic signed [COORD_WIDTH-1:0] req_b1_x,
   input  logic signed [COORD_WIDTH-1:0] req_b1_y,
   input  logic signed [COORD_WIDTH-1:0] req_b1_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_near_a_x,
   output logic signed [COORD_WIDTH-1:0] rsp_near_a_y,
   output logic signed [COORD_WIDTH-1:0] rsp_near_a_z,
   output logic signed [COORD_WIDTH-1:0] rsp_near_b_x,
   output logic signed [COORD_WIDTH-1:0] rsp_near_b_y,
   output logic signed [COORD_WIDTH-1:0] rsp_near_b_z,
   output logic [1:0]                    rsp_status
);

   localparam int CW   = COORD_WIDTH;
   localparam int EW   = CW + 1;              // direction / offset vectors
   localparam int DW   = 2 * CW + 4;          // dot products
   localparam int XW   = 2 * DW + 1;          // det, sa, sb
   localparam int NW   = EW + XW;             // division numerators
   localparam int QB   = CW + 1;              // quotient bits kept
   localparam int T2W  = 2 * TOL_W + 1;       // T^2 as signed
   localparam int THW  = T2W + DW;            // T^2 * max(a, c)
   localparam int CMPW = THW + 1;
   localparam int LW1  = XW + TOL_SHIFT + 1;
   localparam int LW2  = XW + 2 * TOL_SHIFT + 2;
   localparam int NF   = 10;                  // front stages
   localparam longint SMAX_L = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint SMIN_L = -(longint'(1) <<< (CW - 1));

   typedef struct packed {
      logic [2:0][CW-1:0]   a0;
      logic [2:0][CW-1:0]   b0;
      logic [2:0][EW-1:0]   d1;
      logic [2:0][EW-1:0]   d2;
      logic [2:0][EW-1:0]   rv;
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic signed [DW-1:0] c;
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] e;
      logic signed [XW-1:0] det;
      logic signed [XW-1:0] sa;
      logic signed [XW-1:0] sb;
      logic signed [THW-1:0] thr;
      logic [2:0][NW-1:0]   npa;
      logic [2:0][NW-1:0]   npb;
      logic                 ca;
      logic                 cl;
      logic                 alt;
      logic                 clt;
      logic                 par;
      logic                 dgn;
   } front_type;

   logic             en;
   logic [TOL_W-1:0] tol_ff;
   logic signed [T2W-1:0] t2s;

   front_type pf_ff [NF];
   front_type pf_in [NF];
   logic      v_ff  [NF];

   logic signed [2*EW-1:0] prod_ff [15];
   logic signed [2*EW-1:0] prod_in [15];

   logic signed [DW-1:0]    mx;
   logic signed [2*DW-1:0]  ac_p, bb_p, be_p, cd_p, ae_p, bd_p;
   logic signed [THW-1:0]   thr_p;
   logic signed [EW+DW-1:0] pe_p [3];
   logic signed [EW+DW-1:0] pd_p [3];
   logic signed [T2W+2*DW-1:0] tac_p;
   logic signed [2*THW-1:0] thr2_p;
   logic signed [NW-1:0]    ds_p [6];

   logic signed [CMPW-1:0] a_sh, c_sh, thr_x;
   logic signed [LW1-1:0]  det_sh1;
   logic signed [LW2-1:0]  det_sh2;

   // divider pipeline, six lanes: x,y,z of A then of B
   logic [NW-1:0]        dv_r_ff    [QB+1][6];
   logic [NW-1:0]        dv_r_in    [QB+1][6];
   logic [XW-1:0]        dv_den_ff  [QB+1][6];
   logic [XW-1:0]        dv_den_in  [QB+1][6];
   logic [QB-1:0]        dv_q_ff    [QB+1][6];
   logic [QB-1:0]        dv_q_in    [QB+1][6];
   logic                 dv_neg_ff  [QB+1][6];
   logic                 dv_neg_in  [QB+1][6];
   logic                 dv_ovf_ff  [QB+1][6];
   logic                 dv_ovf_in  [QB+1][6];
   logic signed [CW-1:0] dv_base_ff [QB+1][6];
   logic signed [CW-1:0] dv_base_in [QB+1][6];
   logic                 sd_v_ff    [QB+1];
   logic [1:0]           sd_st_ff   [QB+1];
   logic [1:0]           sd_st_in;
   logic                 sd_zero_ff [QB+1];
   logic                 sd_zero_in;

   logic signed [NW-1:0] num_sel [6];
   logic [NW:0]          trial;

   logic                 rnd;
   logic [QB:0]          qr;
   logic signed [QB+1:0] off;
   logic signed [CW+2:0] sum;
   logic                 any_sat;
   logic signed [CW-1:0] out_in [6];
   logic [1:0]           status_in;

   logic                 rsp_valid_ff;
   logic signed [CW-1:0] out_ff [6];
   logic [1:0]           status_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign t2s       = T2W'(tol_ff * tol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write) begin
         tol_ff <= csr_wdata;
      end
   end

   // ---------------- front: differences, dot products, flags ----------------
   always_comb begin
      for (int s = 1; s < NF; s++) begin
         pf_in[s] = pf_ff[s-1];
      end
      pf_in[0] = pf_ff[0];
      pf_in[0].a0 = {req_a0_z, req_a0_y, req_a0_x};
      pf_in[0].b0 = {req_b0_z, req_b0_y, req_b0_x};
      pf_in[0].d1[0] = EW'(req_a1_x) - EW'(req_a0_x);
      pf_in[0].d1[1] = EW'(req_a1_y) - EW'(req_a0_y);
      pf_in[0].d1[2] = EW'(req_a1_z) - EW'(req_a0_z);
      pf_in[0].d2[0] = EW'(req_b1_x) - EW'(req_b0_x);
      pf_in[0].d2[1] = EW'(req_b1_y) - EW'(req_b0_y);
      pf_in[0].d2[2] = EW'(req_b1_z) - EW'(req_b0_z);
      pf_in[0].rv[0] = EW'(req_a0_x) - EW'(req_b0_x);
      pf_in[0].rv[1] = EW'(req_a0_y) - EW'(req_b0_y);
      pf_in[0].rv[2] = EW'(req_a0_z) - EW'(req_b0_z);

      for (int k = 0; k < 3; k++) begin
         prod_in[k]      = $signed(pf_ff[0].d1[k]) * $signed(pf_ff[0].d1[k]);
         prod_in[3 + k]  = $signed(pf_ff[0].d1[k]) * $signed(pf_ff[0].d2[k]);
         prod_in[6 + k]  = $signed(pf_ff[0].d2[k]) * $signed(pf_ff[0].d2[k]);
         prod_in[9 + k]  = $signed(pf_ff[0].d1[k]) * $signed(pf_ff[0].rv[k]);
         prod_in[12 + k] = $signed(pf_ff[0].d2[k]) * $signed(pf_ff[0].rv[k]);
      end

      pf_in[2].a = DW'(prod_ff[0])  + DW'(prod_ff[1])  + DW'(prod_ff[2]);
      pf_in[2].b = DW'(prod_ff[3])  + DW'(prod_ff[4])  + DW'(prod_ff[5]);
      pf_in[2].c = DW'(prod_ff[6])  + DW'(prod_ff[7])  + DW'(prod_ff[8]);
      pf_in[2].d = DW'(prod_ff[9])  + DW'(prod_ff[10]) + DW'(prod_ff[11]);
      pf_in[2].e = DW'(prod_ff[12]) + DW'(prod_ff[13]) + DW'(prod_ff[14]);

      // multiplier results for the item in stage 5
      pf_in[6].det = XW'(ac_p) - XW'(bb_p);
      pf_in[6].sa  = XW'(be_p) - XW'(cd_p);
      pf_in[6].sb  = XW'(ae_p) - XW'(bd_p);
      pf_in[6].thr = thr_p;
      for (int k = 0; k < 3; k++) begin
         pf_in[6].npb[k] = NW'(pe_p[k]);
         pf_in[6].npa[k] = -NW'(pd_p[k]);
      end
      a_sh  = CMPW'(pf_ff[5].a) <<< TOL_SHIFT;
      c_sh  = CMPW'(pf_ff[5].c) <<< TOL_SHIFT;
      thr_x = CMPW'(thr_p);
      pf_in[6].ca  = a_sh > thr_x;
      pf_in[6].cl  = c_sh > thr_x;
      pf_in[6].alt = a_sh < thr_x;
      pf_in[6].clt = c_sh < thr_x;

      // parallel and degenerate tests for the item in stage 8
      det_sh1 = LW1'(pf_ff[8].det) <<< TOL_SHIFT;
      det_sh2 = LW2'(pf_ff[8].det) <<< (2 * TOL_SHIFT);
      pf_in[9].par = (pf_ff[8].a == '0) || (pf_ff[8].c == '0) ||
                     (det_sh1 < LW1'(tac_p));
      pf_in[9].dgn = pf_ff[8].alt || pf_ff[8].clt || (det_sh2 < LW2'(thr2_p)) ||
                     (pf_ff[8].det == '0) || pf_ff[8].det[XW-1];
   end

   assign mx = (pf_ff[2].a >= pf_ff[2].c) ? pf_ff[2].a : pf_ff[2].c;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NF; s++) begin
            pf_ff[s] <= pf_in[s];
         end
         for (int k = 0; k < 15; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NF; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int s = 1; s < NF; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // products fed from stage 2, results line up with stage 5
   lpcp_mul #(.AW(DW), .BW(DW)) u_mul_ac (
      .clock(clock), .en(en), .a(pf_ff[2].a), .b(pf_ff[2].c), .p(ac_p));
   lpcp_mul #(.AW(DW), .BW(DW)) u_mul_bb (
      .clock(clock), .en(en), .a(pf_ff[2].b), .b(pf_ff[2].b), .p(bb_p));
   lpcp_mul #(.AW(DW), .BW(DW)) u_mul_be (
      .clock(clock), .en(en), .a(pf_ff[2].b), .b(pf_ff[2].e), .p(be_p));
   lpcp_mul #(.AW(DW), .BW(DW)) u_mul_cd (
      .clock(clock), .en(en), .a(pf_ff[2].c), .b(pf_ff[2].d), .p(cd_p));
   lpcp_mul #(.AW(DW), .BW(DW)) u_mul_ae (
      .clock(clock), .en(en), .a(pf_ff[2].a), .b(pf_ff[2].e), .p(ae_p));
   lpcp_mul #(.AW(DW), .BW(DW)) u_mul_bd (
      .clock(clock), .en(en), .a(pf_ff[2].b), .b(pf_ff[2].d), .p(bd_p));
   lpcp_mul #(.AW(T2W), .BW(DW)) u_mul_thr (
      .clock(clock), .en(en), .a(t2s), .b(mx), .p(thr_p));

   // products fed from stage 5, results line up with stage 8
   lpcp_mul #(.AW(T2W), .BW(2 * DW)) u_mul_tac (
      .clock(clock), .en(en), .a(t2s), .b(ac_p), .p(tac_p));
   lpcp_mul #(.AW(THW), .BW(THW)) u_mul_thr2 (
      .clock(clock), .en(en), .a(thr_p), .b(thr_p), .p(thr2_p));

   for (genvar g = 0; g < 3; g++) begin : g_lane
      lpcp_mul #(.AW(EW), .BW(DW)) u_mul_pe (
         .clock(clock), .en(en), .a(pf_ff[2].d2[g]), .b(pf_ff[2].e), .p(pe_p[g]));
      lpcp_mul #(.AW(EW), .BW(DW)) u_mul_pd (
         .clock(clock), .en(en), .a(pf_ff[2].d1[g]), .b(pf_ff[2].d), .p(pd_p[g]));
      // fed from stage 6, results line up with stage 9
      lpcp_mul #(.AW(EW), .BW(XW)) u_mul_dsa (
         .clock(clock), .en(en), .a(pf_ff[6].d1[g]), .b(pf_ff[6].sa), .p(ds_p[g]));
      lpcp_mul #(.AW(EW), .BW(XW)) u_mul_dsb (
         .clock(clock), .en(en), .a(pf_ff[6].d2[g]), .b(pf_ff[6].sb), .p(ds_p[3+g]));
   end

   // ---------------- divider: entry, one quotient bit per stage ----------------
   always_comb begin
      trial = '0;
      sd_st_in   = pf_ff[9].par ? ST_PARALLEL : ST_SKEW;
      sd_zero_in = !pf_ff[9].par && pf_ff[9].dgn;
      for (int k = 0; k < 3; k++) begin
         dv_base_in[0][k]     = $signed(pf_ff[9].a0[k]);
         dv_base_in[0][3 + k] = $signed(pf_ff[9].b0[k]);
         if (!pf_ff[9].par) begin
            num_sel[k]          = ds_p[k];
            dv_den_in[0][k]     = pf_ff[9].det;
            num_sel[3 + k]      = ds_p[3 + k];
            dv_den_in[0][3 + k] = pf_ff[9].det;
         end else begin
            // parallel: project a0 onto line B, else b0 onto line A, else none
            if (!pf_ff[9].cl && pf_ff[9].ca) begin
               num_sel[k]      = $signed(pf_ff[9].npa[k]);
               dv_den_in[0][k] = XW'(pf_ff[9].a);
            end else begin
               num_sel[k]      = '0;
               dv_den_in[0][k] = XW'(1);
            end
            if (pf_ff[9].cl) begin
               num_sel[3 + k]      = $signed(pf_ff[9].npb[k]);
               dv_den_in[0][3 + k] = XW'(pf_ff[9].c);
            end else begin
               num_sel[3 + k]      = '0;
               dv_den_in[0][3 + k] = XW'(1);
            end
         end
      end
      for (int l = 0; l < 6; l++) begin
         dv_neg_in[0][l] = num_sel[l][NW-1];
         dv_r_in[0][l]   = num_sel[l][NW-1] ? NW'(-num_sel[l]) : NW'(num_sel[l]);
         dv_q_in[0][l]   = '0;
         // quotient would not fit in QB bits: result saturates for sure
         dv_ovf_in[0][l] = dv_r_in[0][l] >= (NW'(dv_den_in[0][l]) << QB);
      end
      for (int s = 1; s <= QB; s++) begin
         for (int l = 0; l < 6; l++) begin
            dv_den_in[s][l]  = dv_den_ff[s-1][l];
            dv_neg_in[s][l]  = dv_neg_ff[s-1][l];
            dv_ovf_in[s][l]  = dv_ovf_ff[s-1][l];
            dv_base_in[s][l] = dv_base_ff[s-1][l];
            dv_q_in[s][l]    = dv_q_ff[s-1][l];
            trial = {1'b0, dv_r_ff[s-1][l]} - ((NW+1)'(dv_den_ff[s-1][l]) << (QB - s));
            if (!trial[NW]) begin
               dv_r_in[s][l]          = trial[NW-1:0];
               dv_q_in[s][l][QB - s]  = 1'b1;
            end else begin
               dv_r_in[s][l] = dv_r_ff[s-1][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= QB; s++) begin
            for (int l = 0; l < 6; l++) begin
               dv_r_ff[s][l]    <= dv_r_in[s][l];
               dv_den_ff[s][l]  <= dv_den_in[s][l];
               dv_q_ff[s][l]    <= dv_q_in[s][l];
               dv_neg_ff[s][l]  <= dv_neg_in[s][l];
               dv_ovf_ff[s][l]  <= dv_ovf_in[s][l];
               dv_base_ff[s][l] <= dv_base_in[s][l];
            end
         end
         sd_st_ff[0]   <= sd_st_in;
         sd_zero_ff[0] <= sd_zero_in;
         for (int s = 1; s <= QB; s++) begin
            sd_st_ff[s]   <= sd_st_ff[s-1];
            sd_zero_ff[s] <= sd_zero_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QB; s++) begin
            sd_v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         sd_v_ff[0] <= v_ff[NF-1];
         for (int s = 1; s <= QB; s++) begin
            sd_v_ff[s] <= sd_v_ff[s-1];
         end
      end
   end

   // ---------------- rounding, placement, saturation ----------------
   always_comb begin
      any_sat = 1'b0;
      rnd = 1'b0;
      qr  = '0;
      off = '0;
      sum = '0;
      for (int l = 0; l < 6; l++) begin
         rnd = {dv_r_ff[QB][l], 1'b0} >= (NW+1)'(dv_den_ff[QB][l]);
         qr  = (QB+1)'(dv_q_ff[QB][l]) + (QB+1)'(rnd);
         off = dv_neg_ff[QB][l] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
         sum = (CW+3)'(dv_base_ff[QB][l]) + (CW+3)'(off);
         if (dv_ovf_ff[QB][l]) begin
            any_sat   = 1'b1;
            out_in[l] = dv_neg_ff[QB][l] ? CW'(SMIN_L) : CW'(SMAX_L);
         end else if (sum > (CW+3)'(SMAX_L)) begin
            any_sat   = 1'b1;
            out_in[l] = CW'(SMAX_L);
         end else if (sum < (CW+3)'(SMIN_L)) begin
            any_sat   = 1'b1;
            out_in[l] = CW'(SMIN_L);
         end else begin
            out_in[l] = sum[CW-1:0];
         end
      end
      status_in = any_sat ? ST_SATURATED : sd_st_ff[QB];
      if (sd_zero_ff[QB]) begin
         for (int l = 0; l < 6; l++) begin
            out_in[l] = '0;
         end
         status_in = ST_DEGENERATE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 6; l++) begin
            out_ff[l] <= out_in[l];
         end
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sd_v_ff[QB];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_near_a_x = out_ff[0];
   assign rsp_near_a_y = out_ff[1];
   assign rsp_near_a_z = out_ff[2];
   assign rsp_near_b_x = out_ff[3];
   assign rsp_near_b_y = out_ff[4];
   assign rsp_near_b_z = out_ff[5];
   assign rsp_status   = status_ff;

endmodule

`default_nettype wire

[rtl/lpcp_chk.sv]
// Port-level checker for the line pair closest points unit, with its bind.
`default_nettype none

module lpcp_chk
   import lpcp_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_WIDTH-1:0] rsp_near_a_x,
   input logic signed [COORD_WIDTH-1:0] rsp_near_a_y,
   input logic signed [COORD_WIDTH-1:0] rsp_near_a_z,
   input logic signed [COORD_WIDTH-1:0] rsp_near_b_x,
   input logic signed [COORD_WIDTH-1:0] rsp_near_b_y,
   input logic signed [COORD_WIDTH-1:0] rsp_near_b_z,
   input logic [1:0]                    rsp_status
);

   // a stalled transaction keeps its payload (checked on near_a_x, near_b_z and status)
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_near_a_x) &&
      $stable(rsp_near_b_z) && $stable(rsp_status))
      else $error("rsp payload changed while stalled");

   // input side only stalls when the output register is full and blocked
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output backpressure");

   // degenerate result carries all-zero coordinates
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DEGENERATE |->
      rsp_near_a_x == '0 && rsp_near_a_y == '0 && rsp_near_a_z == '0 &&
      rsp_near_b_x == '0 && rsp_near_b_y == '0 && rsp_near_b_z == '0)
      else $error("degenerate result with nonzero coordinates");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind line_pair_closest_points_3d_unit lpcp_chk #(.COORD_WIDTH(COORD_WIDTH)) u_lpcp_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_near_a_x (rsp_near_a_x),
   .rsp_near_a_y (rsp_near_a_y),
   .rsp_near_a_z (rsp_near_a_z),
   .rsp_near_b_x (rsp_near_b_x),
   .rsp_near_b_y (rsp_near_b_y),
   .rsp_near_b_z (rsp_near_b_z),
   .rsp_status   (rsp_status)
);

`default_nettype wire
